// File: design/tss_pkg.sv
package tss_pkg;

  localparam int STEP_COUNT_DEF    = 16;
  localparam int COUNTER_WIDTH_DEF = 23;
  localparam int PERIOD_W          = 23;
  localparam int LOOP_W            = 5;
  localparam int OCTAVE_W          = 4;
  localparam int STEP_W            = 4;
  localparam int NOTE_W            = 8;
  localparam int PITCH_W           = 16;
  localparam int CFG_DATA_W        = 64;
  localparam int CFG_IDX_W         = 3;

  localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST = PERIOD_W'(24000);
  localparam logic [LOOP_W-1:0]   LOOP_LENGTH_RST = LOOP_W'(16);

  // (m*8192 + 30) / 60 == (m*2048 + 7) / 15, the latter by reciprocal
  localparam int MAG_W       = 8;
  localparam int SCALED_W    = MAG_W + 11;
  localparam int RECIP_W     = 24;
  localparam int RECIP_SHIFT = 27;
  localparam int PROD_W      = SCALED_W + RECIP_W;
  localparam logic [SCALED_W-1:0] ROUND_BIAS = SCALED_W'(7);
  localparam logic [RECIP_W-1:0]  RECIP_15   = RECIP_W'(8947849);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_PERIOD     = 3'd0,
    CFG_LOOP_LENGTH     = 3'd1,
    CFG_OCTAVE_OFFSET   = 3'd2,
    CFG_STEP_NOTES_LOW  = 3'd3,
    CFG_STEP_NOTES_HIGH = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [PERIOD_W-1:0]        step_period;
    logic [LOOP_W-1:0]          loop_length;
    logic signed [OCTAVE_W-1:0] octave_offset;
    logic [CFG_DATA_W-1:0]      step_notes_low;
    logic [CFG_DATA_W-1:0]      step_notes_high;
  } cfg_t;

  typedef struct packed {
    logic reset_gate;
    logic forward_gate;
    logic backward_gate;
  } in_word_t;

  typedef struct packed {
    logic signed [PITCH_W-1:0] pitch_cv;
    logic [STEP_W-1:0]         current_step;
  } out_word_t;

  typedef struct packed {
    logic              valid;
    logic [STEP_W-1:0] step;
  } step_word_t;

endpackage

// File: design/tss_step_ctrl.sv
module tss_step_ctrl #(
  parameter int STEP_COUNT    = tss_pkg::STEP_COUNT_DEF,
  parameter int COUNTER_WIDTH = tss_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tss_pkg::in_word_t    in_data,
  input  tss_pkg::cfg_t        cfg,
  output tss_pkg::step_word_t  s1,
  input  logic                 s1_ready
);

  localparam int CMP_W = (COUNTER_WIDTH > tss_pkg::PERIOD_W) ? COUNTER_WIDTH
                                                              : tss_pkg::PERIOD_W;

  logic                        s1_valid_r;
  logic [tss_pkg::STEP_W-1:0]  step_r, step_nxt, step_fwd, step_inc;
  logic [COUNTER_WIDTH-1:0]    cnt_r, cnt_nxt, cnt_inc;
  logic [tss_pkg::LOOP_W-1:0]  loop_len;
  logic                        accept, advance;

  assign in_ready = !s1_valid_r || s1_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (cfg.loop_length == '0) begin
      loop_len = tss_pkg::LOOP_W'(1);
    end else if (cfg.loop_length > tss_pkg::LOOP_W'(STEP_COUNT)) begin
      loop_len = tss_pkg::LOOP_W'(STEP_COUNT);
    end else begin
      loop_len = cfg.loop_length;
    end
  end

  assign cnt_inc = (cnt_r != '1) ? cnt_r + COUNTER_WIDTH'(1) : cnt_r;
  assign advance = (in_data.forward_gate || in_data.backward_gate) &&
                   (CMP_W'(cnt_inc) > CMP_W'(cfg.step_period));

  always_comb begin
    step_inc = step_r + tss_pkg::STEP_W'(1);
    step_fwd = step_r;
    if (in_data.forward_gate) begin
      step_fwd = ({1'b0, step_inc} >= loop_len) ? '0 : step_inc;
    end
    step_nxt = step_fwd;
    if (in_data.backward_gate) begin
      step_nxt = (step_fwd == '0) ? tss_pkg::STEP_W'(loop_len - tss_pkg::LOOP_W'(1))
                                  : step_fwd - tss_pkg::STEP_W'(1);
    end
    cnt_nxt = cnt_inc;
    if (in_data.reset_gate) begin
      step_nxt = '0;
      cnt_nxt  = '0;
    end else if (advance) begin
      cnt_nxt = '0;
    end else begin
      step_nxt = step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      step_r     <= '0;
      cnt_r      <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (accept) begin
        step_r <= step_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  assign s1.valid = s1_valid_r;
  assign s1.step  = step_r;

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.reset_gate |=> step_r == '0 && cnt_r == '0)
    else $error("reset gate did not clear step and counter");

  a_cnt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && $past(rst_n) |-> cnt_r == '0 || cnt_r >= $past(cnt_r))
    else $error("sample counter moved backwards without clearing");

  a_hold_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(step_r) && $stable(cnt_r))
    else $error("state changed without an accepted word");
`endif

endmodule

// File: design/tss_pitch.sv
module tss_pitch (
  input  logic                clk,
  input  logic                rst_n,
  input  tss_pkg::cfg_t       cfg,
  input  tss_pkg::step_word_t s1,
  output logic                s1_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output tss_pkg::out_word_t  out_data
);

  logic                                 out_valid_r;
  tss_pkg::out_word_t                   out_data_r, out_data_nxt;
  logic [tss_pkg::CFG_DATA_W-1:0]       notes;
  logic signed [tss_pkg::NOTE_W-1:0]    note;
  logic signed [9:0]                    oct_ext, note_sum;
  logic [9:0]                           sum_abs;
  logic [tss_pkg::SCALED_W-1:0]         scaled;
  logic [tss_pkg::PROD_W-1:0]           prod;
  logic [tss_pkg::PITCH_W-1:0]          q;

  assign s1_ready = !out_valid_r || out_ready;

  always_comb begin
    notes    = s1.step[3] ? cfg.step_notes_high : cfg.step_notes_low;
    note     = notes[{s1.step[2:0], 3'b000} +: tss_pkg::NOTE_W];
    oct_ext  = 10'(cfg.octave_offset);
    note_sum = 10'(note) + (oct_ext <<< 3) + (oct_ext <<< 2);
    sum_abs  = note_sum[9] ? 10'(-note_sum) : 10'(note_sum);
    scaled   = {sum_abs[tss_pkg::MAG_W-1:0], 11'b0} + tss_pkg::ROUND_BIAS;
    prod     = tss_pkg::PROD_W'(scaled) * tss_pkg::PROD_W'(tss_pkg::RECIP_15);
    q        = prod[tss_pkg::RECIP_SHIFT +: tss_pkg::PITCH_W];
    out_data_nxt.pitch_cv     = note_sum[9] ? -$signed(q) : $signed(q);
    out_data_nxt.current_step = s1.step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_ready) begin
      out_valid_r <= s1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1.valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/tempo_step_sequencer.sv
// an accepted word is held in the step register, then in the pitch register, before out_valid
// throughput: one word per cycle; stalls only when both stages are full
// stage one is the counter and step register, stage two the pitch register
// reset (rst_n low, synchronous) clears counter, step, valid flags and
// loads the register defaults
module tempo_step_sequencer #(
  parameter int STEP_COUNT    = tss_pkg::STEP_COUNT_DEF,
  parameter int COUNTER_WIDTH = tss_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  tss_pkg::in_word_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output tss_pkg::out_word_t                out_data,
  input  logic                              cfg_we,
  input  logic [tss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tss_pkg::CFG_DATA_W-1:0]    cfg_data
);

  tss_pkg::cfg_t       cfg_r;
  tss_pkg::step_word_t s1;
  logic                s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_period     <= tss_pkg::STEP_PERIOD_RST;
      cfg_r.loop_length     <= tss_pkg::LOOP_LENGTH_RST;
      cfg_r.octave_offset   <= '0;
      cfg_r.step_notes_low  <= '0;
      cfg_r.step_notes_high <= '0;
    end else if (cfg_we) begin
      case (tss_pkg::cfg_idx_t'(cfg_index))
        tss_pkg::CFG_STEP_PERIOD: begin
          cfg_r.step_period <= cfg_data[tss_pkg::PERIOD_W-1:0];
        end
        tss_pkg::CFG_LOOP_LENGTH: begin
          cfg_r.loop_length <= cfg_data[tss_pkg::LOOP_W-1:0];
        end
        tss_pkg::CFG_OCTAVE_OFFSET: begin
          cfg_r.octave_offset <= $signed(cfg_data[tss_pkg::OCTAVE_W-1:0]);
        end
        tss_pkg::CFG_STEP_NOTES_LOW: begin
          cfg_r.step_notes_low <= cfg_data;
        end
        tss_pkg::CFG_STEP_NOTES_HIGH: begin
          cfg_r.step_notes_high <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  tss_step_ctrl #(
    .STEP_COUNT    (STEP_COUNT),
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_step_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .s1       (s1),
    .s1_ready (s1_ready)
  );

  tss_pitch u_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .s1        (s1),
    .s1_ready  (s1_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
